FILE: hw/rtl/nte_pkg.sv
`timescale 1ns / 1ps

package nte_pkg;

	// field widths
	localparam int VALUE_W = 17;
	localparam int CHAR_W  = 7;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 17'd99999;

	// bcd digits of a value up to 99999
	localparam int NUM_DIGITS = 5;
	localparam int DIGITS_W   = 4 * NUM_DIGITS;
	localparam int CONV_STEPS = VALUE_W;
	localparam int STEP_W     = 5;

	// character store: one row of sixteen characters for each word
	localparam int ID_W      = 5;
	localparam int POS_W     = 4;
	localparam int ROM_AW    = ID_W + POS_W;
	localparam int ROM_DEPTH = 1 << ROM_AW;
	localparam int TEXT_W    = 72;

	// word slots of one spelling
	localparam int NUM_SLOTS = 7;
	localparam int SLOT_W    = 3;

	// word codes
	localparam logic [ID_W-1:0] ID_EMPTY    = 5'd0;
	localparam logic [ID_W-1:0] ID_TEN      = 5'd10;
	localparam logic [ID_W-1:0] ID_TENS_BASE = 5'd18;
	localparam logic [ID_W-1:0] ID_THOUSAND = 5'd28;
	localparam logic [ID_W-1:0] ID_HUNDRED  = 5'd29;
	localparam logic [ID_W-1:0] ID_ZERO     = 5'd30;

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;

	// request to the digit converter
	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] value;
	} conv_req_t;

	// answer of the digit converter
	typedef struct packed {
		logic                done;
		logic [DIGITS_W-1:0] digits;
	} conv_rsp_t;

	// access to the character store
	typedef struct packed {
		logic              we;
		logic [ROM_AW-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic              re;
		logic [ROM_AW-1:0] raddr;
	} ram_req_t;

	// text of a word, right-justified
	function automatic logic [TEXT_W-1:0] word_text(input logic [ID_W-1:0] id);
		logic [TEXT_W-1:0] t;
		t = '0;
		unique case (id)
			5'd1:  t = "one";
			5'd2:  t = "two";
			5'd3:  t = "three";
			5'd4:  t = "four";
			5'd5:  t = "five";
			5'd6:  t = "six";
			5'd7:  t = "seven";
			5'd8:  t = "eight";
			5'd9:  t = "nine";
			5'd10: t = "ten";
			5'd11: t = "eleven";
			5'd12: t = "twelve";
			5'd13: t = "thirteen";
			5'd14: t = "fourteen";
			5'd15: t = "fifteen";
			5'd16: t = "sixteen";
			5'd17: t = "seventeen";
			5'd18: t = "eighteen";
			5'd19: t = "nineteen";
			5'd20: t = "twenty";
			5'd21: t = "thirty";
			5'd22: t = "forty";
			5'd23: t = "fifty";
			5'd24: t = "sixty";
			5'd25: t = "seventy";
			5'd26: t = "eighty";
			5'd27: t = "ninety";
			5'd28: t = "thousand";
			5'd29: t = "hundred";
			5'd30: t = "zero";
			default: t = '0;
		endcase
		return t;
	endfunction

	// number of characters of a word
	function automatic logic [POS_W-1:0] word_len(input logic [ID_W-1:0] id);
		logic [POS_W-1:0] n;
		n = '0;
		unique case (id)
			5'd1, 5'd2, 5'd6, 5'd10:                      n = 4'd3;
			5'd4, 5'd5, 5'd9, 5'd30:                      n = 4'd4;
			5'd3, 5'd7, 5'd8, 5'd22, 5'd23, 5'd24:        n = 4'd5;
			5'd11, 5'd12, 5'd20, 5'd21, 5'd26, 5'd27:     n = 4'd6;
			5'd15, 5'd16, 5'd25, 5'd29:                   n = 4'd7;
			5'd13, 5'd14, 5'd18, 5'd19, 5'd28:            n = 4'd8;
			5'd17:                                        n = 4'd9;
			default:                                      n = 4'd0;
		endcase
		return n;
	endfunction

	// character at a position of a word, zero past its end
	function automatic logic [CHAR_W-1:0] char_at(input logic [ID_W-1:0] id,
			input logic [POS_W-1:0] pos);
		logic [TEXT_W-1:0] t;
		logic [POS_W-1:0]  n;
		logic [CHAR_W-1:0] c;
		t = word_text(id);
		n = word_len(id);
		c = CH_NONE;
		if (pos < n) begin
			c = t[8 * (int'(n) - 1 - int'(pos)) +: CHAR_W];
		end
		return c;
	endfunction

	// words of a pair of digits: first word in the upper half
	function automatic logic [2*ID_W-1:0] pair_ids(input logic [3:0] tens,
			input logic [3:0] ones);
		logic [ID_W-1:0] first;
		logic [ID_W-1:0] second;
		if (tens >= 4'd2) begin
			first  = ID_TENS_BASE + {1'b0, tens};
			second = {1'b0, ones};
		end else if (tens == 4'd1) begin
			first  = ID_TEN + {1'b0, ones};
			second = ID_EMPTY;
		end else begin
			first  = {1'b0, ones};
			second = ID_EMPTY;
		end
		return {first, second};
	endfunction

endpackage

FILE: hw/rtl/nte_ram.sv
`timescale 1ns / 1ps

module nte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/nte_bcd.sv
`timescale 1ns / 1ps

module nte_bcd (
	input  logic               clk,
	input  logic               arst_n,
	input  nte_pkg::conv_req_t req,
	output nte_pkg::conv_rsp_t rsp
);
	import nte_pkg::*;

	logic [VALUE_W-1:0]  bin_q;
	logic [DIGITS_W-1:0] bcd_q;
	logic [DIGITS_W-1:0] adj;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// step control, one bit of the value a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(CONV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift register of binary and decimal digits
	always_ff @(posedge clk) begin
		if (req.start) begin
			bin_q <= req.value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[DIGITS_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.digits = bcd_q;

endmodule

FILE: hw/rtl/nte_emit.sv
`timescale 1ns / 1ps

module nte_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [nte_pkg::VALUE_W-1:0] value,
	output nte_pkg::conv_req_t         conv_req,
	input  nte_pkg::conv_rsp_t         conv_rsp,
	output nte_pkg::ram_req_t          ram_req,
	input  logic [nte_pkg::CHAR_W-1:0] ram_rdata,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [nte_pkg::CHAR_W-1:0] character,
	output logic                       last,
	output logic                       out_of_range
);
	import nte_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_IDLE,
		ST_CONV,
		ST_EMIT,
		ST_RANGE
	} state_t;

	state_t            state_q;
	logic [ROM_AW-1:0] ld_addr_q;

	// word plan
	logic [ID_W-1:0]   plan [NUM_SLOTS];
	logic [SLOT_W-1:0] plan_last;
	logic [ID_W-1:0]   ids_q [NUM_SLOTS];
	logic [SLOT_W-1:0] last_slot_q;
	logic [2*ID_W-1:0] pair_hi;
	logic [2*ID_W-1:0] pair_lo;
	logic [3:0]        dig [NUM_DIGITS];

	// walk through the words
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	logic              space_q;
	logic [ID_W-1:0]   cur_id;
	logic [POS_W-1:0]  cur_len;
	logic              word_end;
	logic              word_last;

	// read stage and output register
	logic v_s1;
	logic space_s1;
	logic last_s1;
	logic oor_s1;
	logic advance;
	logic iss_v;
	logic iss_space;
	logic iss_last;
	logic iss_oor;
	logic accept;
	logic oor_in;
	logic out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic last_q;
	logic oor_q;

	assign accept  = in_valid && in_ready;
	assign oor_in  = value > VALUE_MAX;
	assign advance = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// digits and words of the converted value
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			dig[i] = conv_rsp.digits[4*i +: 4];
		end
		pair_hi = pair_ids(dig[4], dig[3]);
		pair_lo = pair_ids(dig[1], dig[0]);
		plan[0] = pair_hi[2*ID_W-1:ID_W];
		plan[1] = pair_hi[ID_W-1:0];
		plan[2] = (dig[4] != 4'd0 || dig[3] != 4'd0) ? ID_THOUSAND : ID_EMPTY;
		plan[3] = {1'b0, dig[2]};
		plan[4] = (dig[2] != 4'd0) ? ID_HUNDRED : ID_EMPTY;
		plan[5] = pair_lo[2*ID_W-1:ID_W];
		plan[6] = pair_lo[ID_W-1:0];
		if (conv_rsp.digits == '0) begin
			plan[0] = ID_ZERO;
		end
		plan_last = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (plan[i] != ID_EMPTY) begin
				plan_last = SLOT_W'(i);
			end
		end
	end

	// current word and where it ends
	assign cur_id    = ids_q[slot_q];
	assign cur_len   = word_len(cur_id);
	assign word_end  = (pos_q == cur_len - POS_W'(1));
	assign word_last = (slot_q == last_slot_q) && word_end;

	// word issued into the read stage
	always_comb begin
		iss_v     = 1'b0;
		iss_space = 1'b0;
		iss_last  = 1'b0;
		iss_oor   = 1'b0;
		unique case (state_q)
			ST_EMIT: begin
				if (advance && cur_len != '0) begin
					iss_v     = 1'b1;
					iss_space = space_q;
					iss_last  = !space_q && word_last;
				end
			end
			ST_RANGE: begin
				if (advance) begin
					iss_v    = 1'b1;
					iss_last = 1'b1;
					iss_oor  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// character store access: fill after reset, then reads
	always_comb begin
		ram_req.we    = (state_q == ST_LOAD);
		ram_req.waddr = ld_addr_q;
		ram_req.wdata = char_at(ld_addr_q[ROM_AW-1:POS_W], ld_addr_q[POS_W-1:0]);
		ram_req.re    = advance;
		ram_req.raddr = {cur_id, pos_q};
	end

	assign conv_req.start = accept && !oor_in;
	assign conv_req.value = value;

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ld_addr_q   <= '0;
			slot_q      <= '0;
			pos_q       <= '0;
			space_q     <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				v_s1        <= iss_v;
				out_valid_q <= v_s1;
			end
			unique case (state_q)
				ST_LOAD: begin
					ld_addr_q <= ld_addr_q + ROM_AW'(1);
					if (ld_addr_q == ROM_AW'(ROM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= oor_in ? ST_RANGE : ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_rsp.done) begin
						state_q <= ST_EMIT;
						slot_q  <= '0;
						pos_q   <= '0;
						space_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (cur_len == '0) begin
						slot_q <= slot_q + SLOT_W'(1);
					end else if (advance) begin
						if (space_q) begin
							space_q <= 1'b0;
						end else if (word_end) begin
							pos_q   <= '0;
							slot_q  <= slot_q + SLOT_W'(1);
							space_q <= 1'b1;
							if (word_last) begin
								state_q <= ST_IDLE;
							end
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				ST_RANGE: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word plan registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CONV && conv_rsp.done) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ids_q[i] <= plan[i];
			end
			last_slot_q <= plan_last;
		end
	end

	// payload of read stage and output register
	always_ff @(posedge clk) begin
		if (advance) begin
			space_s1 <= iss_space;
			last_s1  <= iss_last;
			oor_s1   <= iss_oor;
			if (oor_s1) begin
				char_q <= CH_NONE;
			end else if (space_s1) begin
				char_q <= CH_SPACE;
			end else begin
				char_q <= ram_rdata;
			end
			last_q <= last_s1;
			oor_q  <= oor_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign character    = char_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

endmodule

FILE: hw/rtl/number_to_english_words.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// input   | in_valid / in_ready  | value[16:0]
// output  | out_valid / out_ready| character[6:0], last, out_of_range
//
// after reset the character store is filled, all 512 entries, before the first word
// an accepted value is shifted bit by bit through the decimal converter, the word
// plan is loaded, and the first character passes the read stage and output register
// one character a cycle enters the read stage unless stalled; empty slots give none
// an out-of-range value gives its single word via the read stage and output register
// a stall on the output holds the read stage and the store read data

module number_to_english_words (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [nte_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [nte_pkg::CHAR_W-1:0]  character,
	output logic                        last,
	output logic                        out_of_range
);
	import nte_pkg::*;

	conv_req_t         conv_req;
	conv_rsp_t         conv_rsp;
	ram_req_t          ram_req;
	logic [CHAR_W-1:0] ram_rdata;

	// decimal digit converter
	nte_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.rsp    (conv_rsp)
	);

	// word sequencer
	nte_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.conv_req     (conv_req),
		.conv_rsp     (conv_rsp),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last         (last),
		.out_of_range (out_of_range)
	);

	// character store
	nte_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (ROM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: hw/rtl/nte_chk.sv
`timescale 1ns / 1ps

module nte_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [nte_pkg::CHAR_W-1:0]  character,
	input logic                        last,
	input logic                        out_of_range
);

	// an accepted value holds off the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// a waiting word stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// out-of-range word is a lone final word with no character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> last && character == 7'h00)
		else $error("bad out-of-range word");

	// spelling holds only spaces and lower-case letters
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |->
			character == 7'h20 || (character >= 7'h61 && character <= 7'h7a))
		else $error("character outside the spelling alphabet");

	// the spelling never ends on a space
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && !out_of_range |-> character != 7'h20)
		else $error("spelling ends on a space");

endmodule

bind number_to_english_words nte_chk u_nte_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.character    (character),
	.last         (last),
	.out_of_range (out_of_range)
);
